>>> rtl/edps_pkg.sv
// shared constants and request types for the echo distance pid servo loop
`timescale 1ns / 1ps
package edps_pkg;

    // longest echo that still counts as a return
    localparam logic [11:0] MAX_ECHO_US = 12'd3000;
    // largest valid position, 40 cm in unsigned q6.8
    localparam logic [13:0] POS_LIMIT = 14'd10240;
    // rounding offset and divisor of the echo to position scale
    localparam logic [23:0] POS_ROUND = 24'd500;
    localparam logic [31:0] MILLE = 32'd1000;
    // elapsed time used when two samples share a timestamp
    localparam logic [31:0] DT_DEFAULT = 32'd10;

    // configuration register indexes
    localparam logic [2:0] REG_GAIN_P = 3'd0;
    localparam logic [2:0] REG_GAIN_I = 3'd1;
    localparam logic [2:0] REG_GAIN_D = 3'd2;
    localparam logic [2:0] REG_TARGET = 3'd3;
    localparam logic [2:0] REG_CENTER = 3'd4;
    localparam logic [2:0] REG_MIN    = 3'd5;
    localparam logic [2:0] REG_MAX    = 3'd6;

    // iteration counts of the bit-serial unit
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 72;

    // request to the shared multiply / divide unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [71:0] opa;   // multiplicand in the low 48 bits, or dividend
        logic [31:0] opb;   // multiplier or divisor
    } md_req_t;

    // response of the shared multiply / divide unit
    typedef struct packed {
        logic        done;
        logic [71:0] res;
    } md_rsp_t;

endpackage

>>> rtl/edps_muldiv.sv
// bit-serial unsigned shift-add multiplier and restoring divider
`timescale 1ns / 1ps
module edps_muldiv import edps_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  md_req_t md_req,
    output md_rsp_t md_rsp
);

    logic        busy_reg;
    logic        div_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [47:0] mcand_reg;
    logic [79:0] prod_reg;
    logic [31:0] dvsr_reg;
    logic [31:0] rem_reg;
    logic [71:0] quo_reg;

    logic [48:0] mul_sum;
    logic [32:0] div_trial;
    logic [32:0] div_diff;
    logic        div_fit;
    logic        last;

    // one multiplier bit or one quotient bit per cycle
    always_comb begin
        mul_sum   = {1'b0, prod_reg[79:32]} + (prod_reg[0] ? {1'b0, mcand_reg} : 49'd0);
        div_trial = {rem_reg, quo_reg[71]};
        div_diff  = div_trial - {1'b0, dvsr_reg};
        div_fit   = (div_trial >= {1'b0, dvsr_reg});
        last      = div_reg ? (cnt_reg == 7'(DIV_STEPS - 1)) : (cnt_reg == 7'(MUL_STEPS - 1));
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            div_reg  <= 1'b0;
        end else begin
            done_reg <= busy_reg && last;
            if (md_req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
                div_reg  <= md_req.is_div;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (md_req.start) begin
            mcand_reg <= md_req.opa[47:0];
            prod_reg  <= {48'd0, md_req.opb};
            dvsr_reg  <= md_req.opb;
            rem_reg   <= 32'd0;
            quo_reg   <= md_req.opa;
        end else if (busy_reg) begin
            if (div_reg) begin
                rem_reg <= div_fit ? div_diff[31:0] : div_trial[31:0];
                quo_reg <= {quo_reg[70:0], div_fit};
            end else begin
                prod_reg <= {mul_sum, prod_reg[31:1]};
            end
        end
    end

    assign md_rsp.done = done_reg;
    assign md_rsp.res  = div_reg ? quo_reg : prod_reg[71:0];

endmodule

>>> rtl/echo_distance_pid_servo_loop.sv
// echo distance pid servo loop: sequencer, state and output register
// requests are taken only in idle, one at a time; five multiplies and three
//   divides run one after another on the shared bit-serial unit
// a new request is taken while the previous result still waits at the output
// reset (aresetn low, synchronous) restores the register defaults and clears
//   previous error, integral and previous timestamp
`timescale 1ns / 1ps
module echo_distance_pid_servo_loop import edps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // echo_us [11:0], now_ms [43:12]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // servo_angle [7:0], position_used [21:8]
);

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_POS_GO  = 5'd1;
    localparam logic [4:0] S_POS_WT  = 5'd2;
    localparam logic [4:0] S_EDT_GO  = 5'd3;
    localparam logic [4:0] S_EDT_WT  = 5'd4;
    localparam logic [4:0] S_KP_GO   = 5'd5;
    localparam logic [4:0] S_KP_WT   = 5'd6;
    localparam logic [4:0] S_KI_GO   = 5'd7;
    localparam logic [4:0] S_KI_WT   = 5'd8;
    localparam logic [4:0] S_IDIV_GO = 5'd9;
    localparam logic [4:0] S_IDIV_WT = 5'd10;
    localparam logic [4:0] S_KD_GO   = 5'd11;
    localparam logic [4:0] S_KD_WT   = 5'd12;
    localparam logic [4:0] S_K1K_GO  = 5'd13;
    localparam logic [4:0] S_K1K_WT  = 5'd14;
    localparam logic [4:0] S_DDIV_GO = 5'd15;
    localparam logic [4:0] S_DDIV_WT = 5'd16;
    localparam logic [4:0] S_ANG     = 5'd17;
    localparam logic [4:0] S_OUT     = 5'd18;

    logic [4:0]  state_reg;

    logic [23:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [13:0] target_reg;
    logic [7:0]  center_reg, min_reg, max_reg;

    logic [11:0] echo_reg;
    logic [31:0] now_reg;
    logic [31:0] dt_reg;
    logic [13:0] pos_reg;
    logic [15:0] err_reg;
    logic [15:0] prev_err_reg;
    logic [31:0] prev_time_reg;
    logic [47:0] integ_reg;
    logic [63:0] acc_reg;
    logic [71:0] prod_reg;
    logic        neg_reg;
    logic signed [39:0] ang_reg;

    logic        m_valid_reg;
    logic [7:0]  m_angle_reg;
    logic [13:0] m_pos_reg;

    md_req_t     md_req;
    md_rsp_t     md_rsp;

    logic        s_accept;
    logic [31:0] dt_raw;
    logic [11:0] echo_c;
    logic [23:0] numer;
    logic [13:0] pos_raw, pos_sel;
    logic        err_neg;
    logic [15:0] err_mag;
    logic [23:0] kp_mag, ki_mag, kd_mag;
    logic [47:0] integ_mag;
    logic [16:0] de, de_mag;
    logic [48:0] edt, isum;
    logic [47:0] integ_sat;
    logic [63:0] term;
    logic [63:0] acc_rnd;
    logic signed [39:0] min_ext, max_ext;
    logic [7:0]  angle_sel;
    logic        out_load;

    edps_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .md_req  (md_req),
        .md_rsp  (md_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    // operand preparation
    always_comb begin
        dt_raw    = s_tdata[43:12] - prev_time_reg;
        echo_c    = (echo_reg > MAX_ECHO_US) ? 12'd0 : echo_reg;
        numer     = {echo_c, 12'd0} + {4'd0, echo_c, 8'd0} + POS_ROUND;
        pos_raw   = md_rsp.res[13:0];
        pos_sel   = ((pos_raw == 14'd0) || (pos_raw > POS_LIMIT)) ? target_reg : pos_raw;
        err_neg   = err_reg[15];
        err_mag   = err_neg ? (~err_reg + 16'd1) : err_reg;
        kp_mag    = gain_p_reg[23] ? (~gain_p_reg + 24'd1) : gain_p_reg;
        ki_mag    = gain_i_reg[23] ? (~gain_i_reg + 24'd1) : gain_i_reg;
        kd_mag    = gain_d_reg[23] ? (~gain_d_reg + 24'd1) : gain_d_reg;
        integ_mag = integ_reg[47] ? (~integ_reg + 48'd1) : integ_reg;
        de        = {err_reg[15], err_reg} - {prev_err_reg[15], prev_err_reg};
        de_mag    = de[16] ? (~de + 17'd1) : de;
        edt       = err_neg ? (~{1'b0, md_rsp.res[47:0]} + 49'd1) : {1'b0, md_rsp.res[47:0]};
        isum      = {integ_reg[47], integ_reg} + edt;
        if (isum[48] != isum[47]) begin
            integ_sat = isum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            integ_sat = isum[47:0];
        end
        term      = neg_reg ? (~md_rsp.res[63:0] + 64'd1) : md_rsp.res[63:0];
        acc_rnd   = acc_reg + (acc_reg[63] ? 64'h0000_0000_00FF_FFFF : 64'd0);
        min_ext   = {32'd0, min_reg};
        max_ext   = {32'd0, max_reg};
        if (ang_reg < min_ext) begin
            angle_sel = min_reg;
        end else if (ang_reg > max_ext) begin
            angle_sel = max_reg;
        end else begin
            angle_sel = ang_reg[7:0];
        end
    end

    // requests to the multiply / divide unit
    always_comb begin
        md_req.start  = 1'b0;
        md_req.is_div = 1'b0;
        md_req.opa    = 72'd0;
        md_req.opb    = 32'd0;
        unique case (state_reg)
            S_POS_GO: begin
                md_req.start  = 1'b1;
                md_req.is_div = 1'b1;
                md_req.opa    = {48'd0, numer};
                md_req.opb    = MILLE;
            end
            S_EDT_GO: begin
                md_req.start = 1'b1;
                md_req.opa   = {56'd0, err_mag};
                md_req.opb   = dt_reg;
            end
            S_KP_GO: begin
                md_req.start = 1'b1;
                md_req.opa   = {56'd0, err_mag};
                md_req.opb   = {8'd0, kp_mag};
            end
            S_KI_GO: begin
                md_req.start = 1'b1;
                md_req.opa   = {24'd0, integ_mag};
                md_req.opb   = {8'd0, ki_mag};
            end
            S_IDIV_GO: begin
                md_req.start  = 1'b1;
                md_req.is_div = 1'b1;
                md_req.opa    = prod_reg;
                md_req.opb    = MILLE;
            end
            S_KD_GO: begin
                md_req.start = 1'b1;
                md_req.opa   = {55'd0, de_mag};
                md_req.opb   = {8'd0, kd_mag};
            end
            S_K1K_GO: begin
                md_req.start = 1'b1;
                md_req.opa   = {24'd0, prod_reg[47:0]};
                md_req.opb   = MILLE;
            end
            S_DDIV_GO: begin
                md_req.start  = 1'b1;
                md_req.is_div = 1'b1;
                md_req.opa    = prod_reg;
                md_req.opb    = dt_reg;
            end
            default: begin
                md_req.start = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= 24'hFF8000;
            gain_i_reg <= 24'd66;
            gain_d_reg <= 24'd19661;
            target_reg <= 14'd3584;
            center_reg <= 8'd80;
            min_reg    <= 8'd60;
            max_reg    <= 8'd100;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_GAIN_P: gain_p_reg <= cfg_wdata;
                REG_GAIN_I: gain_i_reg <= cfg_wdata;
                REG_GAIN_D: gain_d_reg <= cfg_wdata;
                REG_TARGET: target_reg <= cfg_wdata[13:0];
                REG_CENTER: center_reg <= cfg_wdata[7:0];
                REG_MIN:    min_reg    <= cfg_wdata[7:0];
                REG_MAX:    max_reg    <= cfg_wdata[7:0];
                default:    ;
            endcase
        end
    end

    // sequencer and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            prev_err_reg  <= 16'd0;
            prev_time_reg <= 32'd0;
            integ_reg     <= 48'd0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_accept) state_reg <= S_POS_GO;
                S_POS_GO:  state_reg <= S_POS_WT;
                S_POS_WT:  if (md_rsp.done) state_reg <= S_EDT_GO;
                S_EDT_GO:  state_reg <= S_EDT_WT;
                S_EDT_WT: if (md_rsp.done) begin
                    integ_reg <= integ_sat;
                    state_reg <= S_KP_GO;
                end
                S_KP_GO:   state_reg <= S_KP_WT;
                S_KP_WT:   if (md_rsp.done) state_reg <= S_KI_GO;
                S_KI_GO:   state_reg <= S_KI_WT;
                S_KI_WT:   if (md_rsp.done) state_reg <= S_IDIV_GO;
                S_IDIV_GO: state_reg <= S_IDIV_WT;
                S_IDIV_WT: if (md_rsp.done) state_reg <= S_KD_GO;
                S_KD_GO:   state_reg <= S_KD_WT;
                S_KD_WT:   if (md_rsp.done) state_reg <= S_K1K_GO;
                S_K1K_GO:  state_reg <= S_K1K_WT;
                S_K1K_WT:  if (md_rsp.done) state_reg <= S_DDIV_GO;
                S_DDIV_GO: state_reg <= S_DDIV_WT;
                S_DDIV_WT: if (md_rsp.done) state_reg <= S_ANG;
                S_ANG:     state_reg <= S_OUT;
                S_OUT: if (out_load) begin
                    prev_err_reg  <= err_reg;
                    prev_time_reg <= now_reg;
                    state_reg     <= S_IDLE;
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    // per-request working registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            echo_reg <= s_tdata[11:0];
            now_reg  <= s_tdata[43:12];
            dt_reg   <= (dt_raw == 32'd0) ? DT_DEFAULT : dt_raw;
            acc_reg  <= {32'd0, center_reg, 24'd0};
        end
        if (state_reg == S_POS_WT && md_rsp.done) begin
            pos_reg <= pos_sel;
            err_reg <= {2'b00, target_reg} - {2'b00, pos_sel};
        end
        // sign of each term follows the signs of its factors
        if (state_reg == S_KP_GO) neg_reg <= gain_p_reg[23] ^ err_neg;
        if (state_reg == S_KI_GO) neg_reg <= gain_i_reg[23] ^ integ_reg[47];
        if (state_reg == S_KD_GO) neg_reg <= gain_d_reg[23] ^ de[16];
        // accumulate the p, i and d terms
        if (md_rsp.done && (state_reg == S_KP_WT || state_reg == S_IDIV_WT
                            || state_reg == S_DDIV_WT)) begin
            acc_reg <= acc_reg + term;
        end
        if (md_rsp.done && (state_reg == S_KI_WT || state_reg == S_KD_WT
                            || state_reg == S_K1K_WT)) begin
            prod_reg <= md_rsp.res;
        end
        // truncate toward zero to whole degrees
        if (state_reg == S_ANG) ang_reg <= acc_rnd[63:24];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_angle_reg <= angle_sel;
            m_pos_reg   <= pos_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_pos_reg, m_angle_reg};

endmodule
